// ----- rtl/core/dorr_pkg.sv -----
// types and constants shared by the record ring
`default_nettype none
package dorr_pkg;

  // actions
  localparam logic [2:0] ACT_APPEND = 3'd0;
  localparam logic [2:0] ACT_READ   = 3'd1;
  localparam logic [2:0] ACT_DROP   = 3'd2;
  localparam logic [2:0] ACT_CLEAR  = 3'd3;
  localparam logic [2:0] ACT_PEEK   = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOREC   = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;
  localparam logic [1:0] ST_OFFSET  = 2'd3;

  // header length field and the address accumulator (pointer plus record size)
  localparam int unsigned HdrBytes = 2;
  localparam int unsigned AccW     = 18;
  localparam int unsigned SizeW    = 17;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [11:0] record_len;
    logic [9:0]  msg_index;
    logic [10:0] byte_offset;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [11:0] record_size;
    logic [31:0] id_word;
    logic [10:0] entry_count;
    logic [11:0] bytes_used;
  } out_beat_t;

endpackage
`default_nettype wire

// ----- rtl/core/drop_oldest_record_ring.sv -----
// byte ring of variable-length records with drop-oldest on overflow
//
//   channel | direction | handshake                | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (in_beat_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (out_beat_t)
//   cfg     | input     | cfg_we_i                 | cfg_wdata_i (header_big_endian)
//
// a sequencer drives one address adder/reducer and one byte memory port.
// a new beat is taken while a result waits; a first append byte adds a room check.
// a byte fetch reduces its address by repeated subtraction; a header is 2 fetches.
// a read fetches msg_index+1 headers, reducing each skip address, then the byte.
// each drop fetches a header, then reduces the new oldest pointer unless none is left.
// reset clears the sequencer, pointers, counts, header order and out_valid.
`default_nettype none
module drop_oldest_record_ring #(
  parameter int unsigned STORE_BYTES = 2048
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire                  cfg_wdata_i,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  dorr_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output dorr_pkg::out_beat_t  out_data_o
);
  import dorr_pkg::*;

  localparam int unsigned PW = $clog2(STORE_BYTES);
  localparam int unsigned UW = PW + 1;
  localparam logic [AccW-1:0] SACC = AccW'(STORE_BYTES);
  localparam logic [UW-1:0]   SU   = UW'(STORE_BYTES);

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_RED  = 4'd2;
  localparam logic [3:0] S_H1   = 4'd3;
  localparam logic [3:0] S_H2   = 4'd4;
  localparam logic [3:0] S_APCK = 4'd5;
  localparam logic [3:0] S_DRA  = 4'd6;
  localparam logic [3:0] S_DRB  = 4'd7;
  localparam logic [3:0] S_RW   = 4'd8;
  localparam logic [3:0] S_RW2  = 4'd9;
  localparam logic [3:0] S_RW3  = 4'd10;
  localparam logic [3:0] S_RW4  = 4'd11;
  localparam logic [3:0] S_PK0  = 4'd12;
  localparam logic [3:0] S_PK1  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state_q, state_d, ret_q, ret_d, hret_q, hret_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic [PW-1:0] pos_q, pos_d, oldest_q, oldest_d, wpos_q, wpos_d;
  logic [UW-1:0] used_q, used_d, count_q, count_d, pend_q, pend_d, plen_q, plen_d;
  logic [9:0] k_q, k_d;
  logic [7:0] b0_q, b0_d;
  logic [SizeW-1:0] size_q, size_d, rsize_q, rsize_d;
  logic [1:0] status_q, status_d;
  logic [7:0] rbyte_q, rbyte_d;
  logic [31:0] idb_q, idb_d;
  logic idok_q, idok_d;
  logic hdr_be_q;
  in_beat_t op_q, op_d;
  logic out_valid_q;
  out_beat_t out_q, out_d;
  logic out_load;

  // memory port
  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;
  logic mem_we, mem_re;
  logic [PW-1:0] mem_waddr;
  logic [7:0] mem_wdata;

  // helpers
  logic [15:0] pair;
  logic [UW-1:0] app_sum, app_addr, wnext_sum, wnext;
  logic [SizeW-1:0] old_size_sat;

  assign pair = hdr_be_q ? {b0_q, rdata_q} : {rdata_q, b0_q};

  assign app_sum   = UW'(wpos_q) + plen_q - pend_q;
  assign app_addr  = (app_sum >= SU) ? app_sum - SU : app_sum;
  assign wnext_sum = UW'(wpos_q) + plen_q;
  assign wnext     = (wnext_sum >= SU) ? wnext_sum - SU : wnext_sum;
  assign old_size_sat = SizeW'(used_q);

  // sequencer
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  hret_d = hret_q;
    acc_d = acc_q;  pos_d = pos_q;  oldest_d = oldest_q;  wpos_d = wpos_q;
    used_d = used_q;  count_d = count_q;  pend_d = pend_q;  plen_d = plen_q;
    k_d = k_q;  b0_d = b0_q;  size_d = size_q;  rsize_d = rsize_q;
    status_d = status_q;  rbyte_d = rbyte_q;  idb_d = idb_q;  idok_d = idok_q;
    op_d = op_q;
    mem_we = 1'b0;  mem_re = 1'b0;
    mem_waddr = wpos_q;  mem_wdata = op_q.data_byte;
    out_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = in_data_i;
          status_d = ST_OK;  rbyte_d = '0;  rsize_d = '0;  idok_d = 1'b0;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_DONE;
        case (op_q.action)
          ACT_APPEND: begin
            if (op_q.first_byte) begin
              pend_d = '0;  plen_d = '0;
              if (op_q.record_len < 12'(HdrBytes) || AccW'(op_q.record_len) > SACC) begin
                status_d = ST_TOOLONG;
              end else begin
                state_d = S_APCK;
              end
            end else if (pend_q != '0) begin
              mem_we = 1'b1;
              mem_waddr = app_addr[PW-1:0];
              pend_d = pend_q - 1'b1;
              if (pend_q == UW'(1)) begin
                wpos_d = wnext[PW-1:0];
                used_d = used_q + plen_q;
                count_d = count_q + 1'b1;
                plen_d = '0;
              end
            end
          end
          ACT_READ: begin
            if (32'(op_q.msg_index) >= 32'(count_q)) begin
              status_d = ST_NOREC;
            end else begin
              pos_d = oldest_q;  k_d = '0;  state_d = S_RW;
            end
          end
          ACT_DROP, ACT_PEEK: begin
            if (count_q == '0) begin
              status_d = ST_NOREC;
            end else begin
              pos_d = oldest_q;  k_d = '0;
              acc_d = AccW'(oldest_q);  ret_d = S_H1;
              hret_d = (op_q.action == ACT_DROP) ? S_DRA : S_PK0;
              state_d = S_RED;
            end
          end
          ACT_CLEAR: begin
            oldest_d = '0;  wpos_d = '0;  used_d = '0;  count_d = '0;
            pend_d = '0;  plen_d = '0;
          end
          default: ;
        endcase
      end
      // shared reducer: take the ring modulus, then fetch that byte
      S_RED: begin
        if (acc_q >= SACC) begin
          acc_d = acc_q - SACC;
        end else begin
          mem_re = 1'b1;
          state_d = ret_q;
        end
      end
      S_H1: begin
        b0_d = rdata_q;
        acc_d = AccW'(pos_q) + AccW'(1);
        ret_d = S_H2;
        state_d = S_RED;
      end
      S_H2: begin
        size_d = SizeW'(pair) + SizeW'(HdrBytes);
        state_d = hret_q;
      end
      // make room for an append, then write its first byte
      S_APCK: begin
        if (count_q != '0 && AccW'(used_q) + AccW'(op_q.record_len) > SACC) begin
          pos_d = oldest_q;
          acc_d = AccW'(oldest_q);  ret_d = S_H1;  hret_d = S_DRA;
          state_d = S_RED;
        end else begin
          mem_we = 1'b1;
          mem_waddr = wpos_q;
          plen_d = UW'(op_q.record_len);
          pend_d = UW'(op_q.record_len) - 1'b1;
          // an append reports no record size, even after drops
          rsize_d = '0;
          state_d = S_DONE;
        end
      end
      // drop oldest record of size size_q
      S_DRA: begin
        if (count_q == UW'(1)) begin
          count_d = '0;  used_d = '0;  oldest_d = wpos_q;
          rsize_d = size_q;
          state_d = (op_q.action == ACT_APPEND) ? S_APCK : S_DONE;
        end else begin
          acc_d = AccW'(oldest_q) + AccW'(size_q);
          ret_d = S_DRB;
          state_d = S_RED;
        end
      end
      S_DRB: begin
        count_d = count_q - 1'b1;
        oldest_d = acc_q[PW-1:0];
        used_d = (size_q > old_size_sat) ? '0 : used_q - UW'(size_q);
        rsize_d = size_q;
        state_d = (op_q.action == ACT_APPEND) ? S_APCK : S_DONE;
      end
      // walk to record msg_index
      S_RW: begin
        acc_d = AccW'(pos_q);  ret_d = S_H1;  hret_d = S_RW2;
        state_d = S_RED;
      end
      S_RW2: begin
        if (k_q < op_q.msg_index) begin
          acc_d = AccW'(pos_q) + AccW'(size_q);
          ret_d = S_RW3;
          state_d = S_RED;
        end else begin
          rsize_d = size_q;
          if (SizeW'(op_q.byte_offset) >= size_q) begin
            status_d = ST_OFFSET;
            state_d = S_DONE;
          end else begin
            acc_d = AccW'(pos_q) + AccW'(op_q.byte_offset);
            ret_d = S_RW4;
            state_d = S_RED;
          end
        end
      end
      S_RW3: begin
        pos_d = acc_q[PW-1:0];
        k_d = k_q + 1'b1;
        state_d = S_RW;
      end
      S_RW4: begin
        rbyte_d = rdata_q;
        state_d = S_DONE;
      end
      // peek id bytes two to five
      S_PK0: begin
        rsize_d = size_q;
        acc_d = AccW'(pos_q) + AccW'(HdrBytes) + AccW'(k_q);
        ret_d = S_PK1;
        state_d = S_RED;
      end
      S_PK1: begin
        idb_d = {idb_q[23:0],
                 (SizeW'(k_q) + SizeW'(HdrBytes) < size_q) ? rdata_q : 8'h00};
        k_d = k_q + 1'b1;
        if (k_q == 10'd3) begin
          idok_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_PK0;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result beat
  always_comb begin
    logic [31:0] cnt32, used32;
    cnt32  = 32'(count_q);
    used32 = 32'(used_q);
    out_d.status      = status_q;
    out_d.read_byte   = rbyte_q;
    out_d.record_size = rsize_q[11:0];
    out_d.id_word     = !idok_q ? 32'h0 :
                        hdr_be_q ? idb_q :
                        {idb_q[23:16], idb_q[31:24], idb_q[7:0], idb_q[15:8]};
    out_d.entry_count = cnt32[10:0];
    out_d.bytes_used  = used32[11:0];
  end

  // byte memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[acc_q[PW-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      oldest_q <= '0;  wpos_q <= '0;  used_q <= '0;  count_q <= '0;
      pend_q <= '0;  plen_q <= '0;
      hdr_be_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      oldest_q <= oldest_d;  wpos_q <= wpos_d;  used_q <= used_d;  count_q <= count_d;
      pend_q <= pend_d;  plen_q <= plen_d;
      if (cfg_we_i) begin
        hdr_be_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ret_q <= ret_d;  hret_q <= hret_d;  acc_q <= acc_d;  pos_q <= pos_d;
    k_q <= k_d;  b0_q <= b0_d;  size_q <= size_d;  rsize_q <= rsize_d;
    status_q <= status_d;  rbyte_q <= rbyte_d;  idb_q <= idb_d;  idok_q <= idok_d;
    op_q <= op_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= SU) else $error("bytes used beyond store size");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (used_q == '0)) else $error("empty ring holds bytes");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("ready during work");

endmodule
`default_nettype wire
